// File: rtl/pid_ctl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_ctl_pkg
// Shared types and constants of the clamped-integrator PID controller.
// ----------------------------------------------------------------------------
package pid_ctl_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    // quotient bits produced by the divider: 32-bit magnitude scaled by 2^16
    localparam int DIV_STEPS  = 48;
    localparam int DIV_CNT_W  = 6;

    typedef logic signed [DATA_W-1:0] q16_t;

    typedef enum logic [1:0] {
        OP_STEP        = 2'd0,
        OP_RESET       = 2'd1,
        OP_INTEG_RESET = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } clamp_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN        = 3'd0,
        REG_INTEG_GAIN       = 3'd1,
        REG_DERIV_GAIN       = 3'd2,
        REG_INTEG_LIMIT_HIGH = 3'd3,
        REG_INTEG_LIMIT_LOW  = 3'd4,
        REG_INTEG_HOLD       = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDT,
        S_P,
        S_KI,
        S_PRES,
        S_INTEG,
        S_DWAIT,
        S_D,
        S_D1,
        S_SUM,
        S_DONE
    } state_t;

    localparam q16_t Q16_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q16_t Q16_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage : pid_ctl_pkg
`default_nettype wire

// File: rtl/pid_ctl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_ctl_if
// Valid/ready channels of the PID controller: input sample and result.
// ----------------------------------------------------------------------------
interface pid_ctl_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] error_in;
    logic signed [31:0] time_step;

    modport source (output valid, op, error_in, time_step, input ready);
    modport sink   (input valid, op, error_in, time_step, output ready);
endinterface : pid_ctl_in_if

interface pid_ctl_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic [1:0]         clamp_state;
    logic               repeated;

    modport source (output valid, drive, clamp_state, repeated, input ready);
    modport sink   (input valid, drive, clamp_state, repeated, output ready);
endinterface : pid_ctl_out_if
`default_nettype wire

// File: rtl/pid_controller_clamped_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_clamped_integrator
// PID step in signed Q16.16 with clamped integrator, sequenced over one
// shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// A control step (op 0, dt > 0) loads a result word into the output
// register. Its derivative quotient comes from a restoring divider that
// produces one of 48 quotient bits per cycle, and three of the four products
// run through one shared two-stage multiplier while the divider works; the
// fourth scales the quotient by the derivative gain. The next sample can be
// taken in the cycle after the word is loaded. The first step after a reset
// skips the divider. A step with dt <= 0 returns the last drive; the reset
// ops give no result. A new sample is taken only when the sequencer is
// idle; the result sits in an output register, so a new sample is accepted
// while the previous result still waits, and a finished step waits until
// that register is free. The user must write registers through
// cfg_we/cfg_index/cfg_data only while no step is in progress; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module pid_controller_clamped_integrator (
    input  wire                                   clk,
    input  wire                                   rst_n,
    pid_ctl_in_if.sink                            sample,
    pid_ctl_out_if.source                         result,
    input  wire                                   cfg_we,
    input  wire  [pid_ctl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [pid_ctl_pkg::DATA_W-1:0]        cfg_data
);
    import pid_ctl_pkg::*;

    // configuration
    q16_t   prop_gain_reg;
    q16_t   integ_gain_reg;
    q16_t   deriv_gain_reg;
    q16_t   limit_high_reg;
    q16_t   limit_low_reg;
    logic   hold_reg;

    // controller state
    q16_t   last_error_reg;
    q16_t   last_drive_reg;
    q16_t   integ_acc_reg;
    logic   first_sample_reg;
    clamp_t clamp_flag_reg;

    // working registers
    state_t state_reg;
    state_t state_next;
    q16_t   e_reg;
    q16_t   dt_reg;
    q16_t   p_reg;
    q16_t   pend_drive_reg;
    clamp_t pend_clamp_reg;
    logic   pend_rep_reg;

    // output word
    logic   out_valid_reg;
    q16_t   out_drive_reg;
    clamp_t out_clamp_reg;
    logic   out_rep_reg;

    logic   accept;
    logic   dt_pos;
    logic   div_start;
    logic   div_busy;
    q16_t   div_quot;
    q16_t   mul_a;
    q16_t   mul_b;
    q16_t   mul_res;
    logic   out_load;

    logic signed [32:0] diff;
    logic signed [32:0] acc_sum;
    logic signed [33:0] drive_sum;
    q16_t   drive_sat;
    q16_t   integ_new;
    clamp_t clamp_new;

    assign accept   = sample.valid && sample.ready;
    assign dt_pos   = !sample.time_step[31] && (|sample.time_step);
    assign diff     = 33'(sample.error_in) - 33'(last_error_reg);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    pid_ctl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (diff),
        .den   (sample.time_step[30:0]),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    pid_ctl_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .res (mul_res)
    );

    // sequencer: next state, multiplier operands, divider start
    always_comb
    begin
        state_next   = state_reg;
        sample.ready = 1'b0;
        div_start    = 1'b0;
        mul_a        = e_reg;
        mul_b        = dt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                sample.ready = 1'b1;
                if (sample.valid && (sample.op == OP_STEP))
                begin
                    if (dt_pos)
                    begin
                        div_start  = !first_sample_reg;
                        state_next = S_EDT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_EDT:
            begin
                state_next = S_P;
            end
            S_P:
            begin
                mul_b      = prop_gain_reg;
                state_next = S_KI;
            end
            S_KI:
            begin
                mul_a      = integ_gain_reg;
                mul_b      = mul_res;
                state_next = S_PRES;
            end
            S_PRES:
            begin
                state_next = S_INTEG;
            end
            S_INTEG:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!div_busy)
                begin
                    state_next = S_D;
                end
            end
            S_D:
            begin
                mul_a      = first_sample_reg ? '0 : div_quot;
                mul_b      = deriv_gain_reg;
                state_next = S_D1;
            end
            S_D1:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // integrator update and clamp, high limit checked first
    always_comb
    begin
        acc_sum = 33'(integ_acc_reg) + 33'(mul_res);
        if (acc_sum > 33'(limit_high_reg))
        begin
            integ_new = limit_high_reg;
            clamp_new = CLAMP_HIGH;
        end
        else if (acc_sum < 33'(limit_low_reg))
        begin
            integ_new = limit_low_reg;
            clamp_new = CLAMP_LOW;
        end
        else
        begin
            integ_new = acc_sum[31:0];
            clamp_new = CLAMP_NONE;
        end
    end

    always_comb
    begin
        drive_sum = 34'(p_reg) + 34'(integ_acc_reg) + 34'(mul_res);
        if (drive_sum > 34'(Q16_MAX))
        begin
            drive_sat = Q16_MAX;
        end
        else if (drive_sum < 34'(Q16_MIN))
        begin
            drive_sat = Q16_MIN;
        end
        else
        begin
            drive_sat = drive_sum[31:0];
        end
    end

    // configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            limit_high_reg   <= Q16_MAX;
            limit_low_reg    <= Q16_MIN;
            hold_reg         <= 1'b0;
            last_error_reg   <= '0;
            last_drive_reg   <= '0;
            integ_acc_reg    <= '0;
            first_sample_reg <= 1'b1;
            clamp_flag_reg   <= CLAMP_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PROP_GAIN:        prop_gain_reg  <= cfg_data;
                    REG_INTEG_GAIN:       integ_gain_reg <= cfg_data;
                    REG_DERIV_GAIN:       deriv_gain_reg <= cfg_data;
                    REG_INTEG_LIMIT_HIGH: limit_high_reg <= cfg_data;
                    REG_INTEG_LIMIT_LOW:  limit_low_reg  <= cfg_data;
                    REG_INTEG_HOLD:       hold_reg       <= cfg_data[0];
                    default:              ;
                endcase
            end

            if (accept && (sample.op == OP_RESET))
            begin
                last_error_reg   <= '0;
                last_drive_reg   <= '0;
                integ_acc_reg    <= '0;
                first_sample_reg <= 1'b1;
                clamp_flag_reg   <= CLAMP_NONE;
            end
            else if (accept && (sample.op == OP_INTEG_RESET))
            begin
                integ_acc_reg  <= '0;
                clamp_flag_reg <= CLAMP_NONE;
            end
            else if ((state_reg == S_INTEG) && !hold_reg)
            begin
                integ_acc_reg  <= integ_new;
                clamp_flag_reg <= clamp_new;
            end
            else if (state_reg == S_SUM)
            begin
                last_error_reg   <= e_reg;
                last_drive_reg   <= drive_sat;
                first_sample_reg <= 1'b0;
            end
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_reg          <= sample.error_in;
            dt_reg         <= sample.time_step;
            pend_drive_reg <= last_drive_reg;
            pend_clamp_reg <= clamp_flag_reg;
            pend_rep_reg   <= 1'b1;
        end
        if (state_reg == S_PRES)
        begin
            p_reg <= mul_res;
        end
        if (state_reg == S_SUM)
        begin
            pend_drive_reg <= drive_sat;
            pend_clamp_reg <= clamp_flag_reg;
            pend_rep_reg   <= 1'b0;
        end
        if (out_load)
        begin
            out_drive_reg <= pend_drive_reg;
            out_clamp_reg <= pend_clamp_reg;
            out_rep_reg   <= pend_rep_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.drive       = out_drive_reg;
    assign result.clamp_state = out_clamp_reg;
    assign result.repeated    = out_rep_reg;

endmodule : pid_controller_clamped_integrator
`default_nettype wire

// File: rtl/pid_ctl_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_ctl_mul
// Shared Q16.16 multiplier: registered 64-bit product, then floor shift by 16
// and saturation into a second register; one product per cycle.
// ----------------------------------------------------------------------------
module pid_ctl_mul (
    input  wire                 clk,
    input  pid_ctl_pkg::q16_t   a,
    input  pid_ctl_pkg::q16_t   b,
    output pid_ctl_pkg::q16_t   res
);
    import pid_ctl_pkg::*;

    logic signed [2*DATA_W-1:0] prod_reg;
    q16_t                       res_reg;
    q16_t                       res_next;

    // arithmetic shift is floor; value fits if the top bits are all sign
    always_comb
    begin
        if (&prod_reg[2*DATA_W-1:DATA_W+FRAC_W-1] || ~|prod_reg[2*DATA_W-1:DATA_W+FRAC_W-1])
        begin
            res_next = prod_reg[DATA_W+FRAC_W-1:FRAC_W];
        end
        else if (prod_reg[2*DATA_W-1])
        begin
            res_next = Q16_MIN;
        end
        else
        begin
            res_next = Q16_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= (2*DATA_W)'(a) * (2*DATA_W)'(b);
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule : pid_ctl_mul
`default_nettype wire

// File: rtl/pid_ctl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_ctl_div
// Restoring divider, one quotient bit per cycle: (diff * 2^16) / den,
// truncated toward zero and saturated to Q16.16. den is positive.
// ----------------------------------------------------------------------------
module pid_ctl_div (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire  signed [32:0]  diff,
    input  wire  [30:0]         den,
    output logic                busy,
    output pid_ctl_pkg::q16_t   quot
);
    import pid_ctl_pkg::*;

    logic                     busy_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic [DIV_STEPS-1:0]     work_reg;
    logic [30:0]              rem_reg;
    logic [30:0]              den_reg;
    logic                     neg_reg;
    q16_t                     quot_reg;

    logic [32:0]              diff_mag;
    logic [31:0]              rem_sh;
    logic                     fit;
    logic [30:0]              rem_next;
    logic [DIV_STEPS-1:0]     work_next;
    q16_t                     quot_next;

    always_comb
    begin
        diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
        rem_sh   = {rem_reg, work_reg[DIV_STEPS-1]};
        fit      = rem_sh >= {1'b0, den_reg};
        rem_next = fit ? 31'(rem_sh - {1'b0, den_reg}) : rem_sh[30:0];
        work_next = {work_reg[DIV_STEPS-2:0], fit};

        // sign and saturation of the finished magnitude
        if (neg_reg)
        begin
            if (|work_reg[DIV_STEPS-1:32] || (work_reg[31] && |work_reg[30:0]))
            begin
                quot_next = Q16_MIN;
            end
            else
            begin
                quot_next = q16_t'(-work_reg[31:0]);
            end
        end
        else
        begin
            if (|work_reg[DIV_STEPS-1:31])
            begin
                quot_next = Q16_MAX;
            end
            else
            begin
                quot_next = q16_t'(work_reg[31:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= {diff_mag[31:0], {FRAC_W{1'b0}}};
            rem_reg  <= '0;
            den_reg  <= den;
            neg_reg  <= diff[32];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS))
            begin
                quot_reg <= quot_next;
            end
            else
            begin
                work_reg <= work_next;
                rem_reg  <= rem_next;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule : pid_ctl_div
`default_nettype wire

// File: tb/pid_controller_clamped_integrator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_integrator_tb
// Drives samples into the PID controller over its valid/ready channel and
// checks every result word against a cycle-free Q16.16 model of the control
// law: saturated products, derivative quotient, clamped integrator, hold,
// repeat on non-positive dt and the two reset ops. Register settings change
// between phases; both channels see random gaps and one long output stall.
// ----------------------------------------------------------------------------
module pid_controller_clamped_integrator_tb;
    import pid_ctl_pkg::*;

    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam int SETTLE_CYCLES     = 64;
    localparam int LONG_HOLD_AT      = 400;
    localparam int LONG_HOLD_CYCLES  = 600;
    localparam int RANDOM_PHASES     = 7;
    localparam int ITEMS_PER_PHASE   = 105;

    typedef struct packed {
        logic [1:0] op;
        q16_t       err;
        q16_t       dt;
    } pid_sample_t;

    typedef struct packed {
        q16_t   drive;
        clamp_t clamp;
        logic   repeated;
    } pid_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    reg_idx_t   cfg_index;
    logic [31:0] cfg_data;

    pid_ctl_in_if  sample_if ();
    pid_ctl_out_if result_if ();

    pid_controller_clamped_integrator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // loop model: register copy and controller state
    q16_t   kp_gain      = '0;
    q16_t   ki_gain      = '0;
    q16_t   kd_gain      = '0;
    q16_t   integ_hi     = Q16_MAX;
    q16_t   integ_lo     = Q16_MIN;
    logic   integ_frozen = 1'b0;

    q16_t   prev_error;
    q16_t   prev_drive;
    q16_t   integ_sum;
    logic   fresh_start;
    clamp_t integ_clamp;

    pid_sample_t sample_queue [$];
    pid_result_t expected_results [$];
    pid_sample_t next_sample;

    logic        in_taken  = 1'b0;
    logic        out_taken = 1'b0;
    logic        calm      = 1'b0;
    int unsigned send_gap  = 0;
    int unsigned recv_gap  = 0;
    int unsigned long_hold_left = 0;
    logic        long_hold_done = 1'b0;

    int unsigned words_in      = 0;
    int unsigned words_out     = 0;
    int unsigned mismatches    = 0;
    int unsigned repeats_seen  = 0;
    int unsigned high_clamps   = 0;
    int unsigned low_clamps    = 0;
    int unsigned held_steps    = 0;
    int unsigned settings_done = 0;

    function automatic q16_t sat_q16(input longint v);
        if (v > longint'(Q16_MAX))
            return Q16_MAX;
        if (v < longint'(Q16_MIN))
            return Q16_MIN;
        return q16_t'(v);
    endfunction

    // full product, floor shift by the fraction width, saturate
    function automatic q16_t fx_mul(input q16_t a, input q16_t b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return sat_q16(prod >>> FRAC_W);
    endfunction

    function automatic void clear_loop_state();
        prev_error  = '0;
        prev_drive  = '0;
        integ_sum   = '0;
        fresh_start = 1'b1;
        integ_clamp = CLAMP_NONE;
    endfunction

    function automatic void pid_step_model(input logic [1:0] op, input q16_t err,
                                           input q16_t dt);
        longint      acc;
        longint      diff;
        q16_t        deriv;
        pid_result_t res;
        deriv = '0;
        if (op == OP_RESET)
        begin
            clear_loop_state();
            return;
        end
        if (op == OP_INTEG_RESET)
        begin
            integ_sum   = '0;
            integ_clamp = CLAMP_NONE;
            return;
        end
        if (op != OP_STEP)
            return;
        if (dt <= 0)
        begin
            res = '{drive: prev_drive, clamp: integ_clamp, repeated: 1'b1};
            expected_results.push_back(res);
            return;
        end
        if (fresh_start)
            fresh_start = 1'b0;
        else
        begin
            diff  = longint'(err) - longint'(prev_error);
            deriv = sat_q16((diff * 65536) / longint'(dt));
        end
        if (!integ_frozen)
        begin
            acc = longint'(integ_sum) + longint'(fx_mul(ki_gain, fx_mul(err, dt)));
            // high limit wins when the limits are crossed
            if (acc > longint'(integ_hi))
            begin
                integ_sum   = integ_hi;
                integ_clamp = CLAMP_HIGH;
            end
            else if (acc < longint'(integ_lo))
            begin
                integ_sum   = integ_lo;
                integ_clamp = CLAMP_LOW;
            end
            else
            begin
                integ_sum   = q16_t'(acc);
                integ_clamp = CLAMP_NONE;
            end
        end
        else
            held_steps++;
        prev_error = err;
        prev_drive = sat_q16(longint'(fx_mul(err, kp_gain)) + longint'(integ_sum)
                             + longint'(fx_mul(deriv, kd_gain)));
        res = '{drive: prev_drive, clamp: integ_clamp, repeated: 1'b0};
        expected_results.push_back(res);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    function automatic q16_t rand_signed(input int unsigned mag_max);
        q16_t m;
        m = q16_t'($urandom_range(0, mag_max));
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic q16_t pick_extreme();
        case ($urandom_range(0, 4))
            0: return Q16_MAX;
            1: return Q16_MIN;
            2: return '0;
            3: return q16_t'(1);
            default: return q16_t'(-1);
        endcase
    endfunction

    function automatic q16_t rand_gain();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return pick_extreme();
        if (r < 25)
            return q16_t'($urandom());
        return rand_signed(32'h0004_0000);
    endfunction

    function automatic q16_t rand_error();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return pick_extreme();
        if (r < 30)
            return q16_t'($urandom());
        return rand_signed(32'h0008_0000);
    endfunction

    function automatic q16_t rand_dt();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 8)
            return q16_t'($urandom() | 32'h8000_0000);
        if (r < 12)
            return $urandom_range(0, 1) ? q16_t'(1) : Q16_MAX;
        if (r < 25)
            return q16_t'($urandom_range(1, 32'h7fff_ffff));
        return q16_t'($urandom_range(32'h40, 32'h1_0000));
    endfunction

    function automatic logic [1:0] rand_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return OP_STEP;
        if (r < 92)
            return OP_RESET;
        if (r < 96)
            return OP_INTEG_RESET;
        return OP_SPARE;
    endfunction

    task automatic queue_sample(input logic [1:0] op, input q16_t err, input q16_t dt);
        pid_sample_t s;
        s = '{op: op, err: err, dt: dt};
        sample_queue.push_back(s);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            REG_PROP_GAIN:        kp_gain      = q16_t'(data);
            REG_INTEG_GAIN:       ki_gain      = q16_t'(data);
            REG_DERIV_GAIN:       kd_gain      = q16_t'(data);
            REG_INTEG_LIMIT_HIGH: integ_hi     = q16_t'(data);
            REG_INTEG_LIMIT_LOW:  integ_lo     = q16_t'(data);
            REG_INTEG_HOLD:       integ_frozen = data[0];
            default: ;
        endcase
    endtask

    task automatic program_loop(input q16_t kp, input q16_t ki, input q16_t kd,
                                input q16_t hi, input q16_t lo, input logic hold);
        logic [31:0] hold_word;
        hold_word    = $urandom();
        hold_word[0] = hold;
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_INTEG_LIMIT_HIGH, hi);
        write_reg(REG_INTEG_LIMIT_LOW, lo);
        write_reg(REG_INTEG_HOLD, hold_word);
        @(negedge clk);
        cfg_we = 1'b0;
        settings_done++;
    endtask

    // samples without a result may still be in flight once the queue drains
    task automatic wait_idle();
        do
            @(posedge clk);
        while (sample_queue.size() != 0 || sample_if.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sample driver
    always @(negedge clk)
    begin
        if (rst_n && (!sample_if.valid || in_taken))
        begin
            if (send_gap != 0)
            begin
                sample_if.valid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (sample_queue.size() != 0)
            begin
                next_sample = sample_queue.pop_front();
                sample_if.op        <= next_sample.op;
                sample_if.error_in  <= next_sample.err;
                sample_if.time_step <= next_sample.dt;
                sample_if.valid     <= 1'b1;
                send_gap = pick_gap();
            end
            else
                sample_if.valid <= 1'b0;
        end
    end

    // accepted samples feed the model
    always @(posedge clk)
    begin
        in_taken <= sample_if.valid && sample_if.ready;
        if (rst_n && sample_if.valid && sample_if.ready)
        begin
            words_in++;
            pid_step_model(sample_if.op, sample_if.error_in, sample_if.time_step);
        end
    end

    // result receiver, with one long stall to back the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && words_in >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                long_hold_left = LONG_HOLD_CYCLES;
                result_if.ready <= 1'b0;
            end
            else if (long_hold_left != 0)
            begin
                long_hold_left = long_hold_left - 1;
                result_if.ready <= 1'b0;
            end
            else
            begin
                if (out_taken)
                    recv_gap = pick_gap();
                if (recv_gap != 0)
                begin
                    recv_gap = recv_gap - 1;
                    result_if.ready <= 1'b0;
                end
                else
                    result_if.ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        pid_result_t want;
        out_taken <= result_if.valid && result_if.ready;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            words_out++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word with nothing pending: drive=%h clamp=%0d rep=%0b",
                             result_if.drive, result_if.clamp_state, result_if.repeated);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.repeated)
                    repeats_seen++;
                if (want.clamp == CLAMP_HIGH)
                    high_clamps++;
                if (want.clamp == CLAMP_LOW)
                    low_clamps++;
                if (result_if.drive !== want.drive || result_if.clamp_state !== want.clamp
                    || result_if.repeated !== want.repeated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: drive %h/%h clamp %0d/%0d rep %0b/%0b (exp/got)",
                                 words_out, want.drive, result_if.drive, want.clamp,
                                 result_if.clamp_state, want.repeated, result_if.repeated);
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        q16_t lim_a;
        q16_t lim_b;
        q16_t swap_tmp;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_PROP_GAIN;
        cfg_data            = '0;
        sample_if.valid     = 1'b0;
        sample_if.op        = OP_STEP;
        sample_if.error_in  = '0;
        sample_if.time_step = '0;
        result_if.ready     = 1'b0;
        clear_loop_state();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // moderate gains, limits at +/-10.0
        program_loop(32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
                     32'h000A_0000, -32'sh000A_0000, 1'b0);
        queue_sample(OP_STEP, 32'h0000_8000, '0);
        queue_sample(OP_STEP, 32'h0001_0000, 32'h0001_0000);
        queue_sample(OP_STEP, 32'h0002_0000, 32'h0000_8000);
        queue_sample(OP_STEP, 32'h0002_0000, Q16_MIN);
        queue_sample(OP_STEP, Q16_MAX, Q16_MAX);
        queue_sample(OP_STEP, Q16_MIN, q16_t'(1));
        queue_sample(OP_STEP, Q16_MIN, Q16_MAX);
        queue_sample(OP_INTEG_RESET, $urandom(), $urandom());
        queue_sample(OP_STEP, '0, 32'h0001_0000);
        queue_sample(OP_RESET, $urandom(), $urandom());
        // dt of zero right after a reset keeps the first-sample state
        queue_sample(OP_STEP, -32'sh0003_0000, '0);
        queue_sample(OP_STEP, -32'sh0003_0000, 32'h0000_4000);
        queue_sample(OP_SPARE, $urandom(), $urandom());
        queue_sample(OP_STEP, q16_t'(-1), q16_t'(1));
        queue_sample(OP_STEP, Q16_MAX, q16_t'(1));
        wait_idle();

        // frozen integrator, extreme limits and derivative gain
        program_loop(-32'sh0001_0000, 32'h0002_0000, Q16_MIN, Q16_MAX, Q16_MIN, 1'b1);
        queue_sample(OP_STEP, 32'h0003_0000, 32'h0001_0000);
        queue_sample(OP_STEP, -32'sh0005_0000, 32'h0000_2000);
        queue_sample(OP_INTEG_RESET, '0, '0);
        queue_sample(OP_STEP, q16_t'(1), 32'h0002_0000);
        wait_idle();

        // crossed limits: the high limit wins
        program_loop(Q16_MAX, Q16_MIN, Q16_MAX, -32'sh0001_0000, 32'h0001_0000, 1'b0);
        queue_sample(OP_STEP, 32'h0000_8000, 32'h0001_0000);
        queue_sample(OP_STEP, -32'sh0000_8000, 32'h0001_0000);
        queue_sample(OP_STEP, '0, '0);
        queue_sample(OP_STEP, Q16_MIN, Q16_MAX);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            lim_a = q16_t'($urandom_range(0, 32'h0032_0000));
            lim_b = -q16_t'($urandom_range(0, 32'h0032_0000));
            if ($urandom_range(0, 9) == 0)
            begin
                swap_tmp = lim_a;
                lim_a    = lim_b;
                lim_b    = swap_tmp;
            end
            calm = (p == 2);
            case (p)
                0: program_loop(Q16_MAX, Q16_MIN, Q16_MAX, Q16_MAX, Q16_MIN, 1'b0);
                1: program_loop(rand_gain(), rand_gain(), rand_gain(), '0, '0, 1'b0);
                3: program_loop(rand_gain(), rand_gain(), rand_gain(), lim_a, lim_b, 1'b1);
                4: program_loop(Q16_MIN, rand_gain(), Q16_MIN, lim_a, lim_b, 1'b0);
                default: program_loop(rand_gain(), rand_gain(), rand_gain(), lim_a, lim_b,
                                      1'b0);
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                queue_sample(rand_op(), rand_error(), rand_dt());
            wait_idle();
        end

        $display("checked %0d result words from %0d samples over %0d register settings",
                 words_out, words_in, settings_done);
        $display("repeats %0d, high clamps %0d, low clamps %0d, held steps %0d",
                 repeats_seen, high_clamps, low_clamps, held_steps);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule : pid_controller_clamped_integrator_tb
